>>> rtl/tvvs_pkg.sv
// shared widths, beat types and latency helper for the triangle volume split
package tvvs_pkg;

    // coordinate and intermediate widths (all exact, no overflow possible)
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SQ_W      = 2 * SUM_W;
    localparam int S_W       = SQ_W + 2;
    localparam int T_W       = 2 * SQ_W;
    localparam int Q_W       = 32;
    localparam int LIMB_W    = 32;
    localparam int FRONT_LAT = 3;

    // input beat: one triangle
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri;

    // output beat: contributions of edges ab, ac and bc and the zero-area flag
    typedef struct packed {
        logic signed [Q_W-1:0] vol_ab;
        logic signed [Q_W-1:0] vol_ac;
        logic signed [Q_W-1:0] vol_bc;
        logic                  degenerate;
    } t_vol;

    // latency of the limb multiplier for operand widths wa and wb
    function automatic int mul_lat(input int wa, input int wb);
        int na;
        int nb;
        na = (wa + LIMB_W - 1) / LIMB_W;
        nb = (wb + LIMB_W - 1) / LIMB_W;
        return 3 + $clog2(na * nb);
    endfunction

endpackage

>>> rtl/tvvs_tri_if.sv
// triangle input channel
interface tvvs_tri_if;
    import tvvs_pkg::*;
    logic valid;
    logic ready;
    t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tvvs_vol_if.sv
// edge volume result channel
interface tvvs_vol_if;
    import tvvs_pkg::*;
    logic valid;
    logic ready;
    t_vol data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/triangle_voronoi_volume_split.sv
// top level: voronoi control-volume split of a triangle into contributions of edges ab, ac and bc
//
// Input channel i_tri carries one triangle per beat (three vertices, signed fixed
// point with FRAC_BITS fraction bits); output channel o_vol carries one beat per
// triangle with the contributions of edges ab, ac and bc and a zero-area flag.
// Both channels use valid/ready; a beat moves when both are high.
//
// Throughput is one triangle per cycle while the skid register is empty. An accepted
// input beat passes the front stages, the first limb multiplier trees, the area
// register, the second limb multiplier trees, the 32-stage square-root-free
// quotient search per edge and the output stage on its way to its output beat.
//
// A one-beat skid register sits behind the output stage, so the input is still
// taken in the cycle a finished beat first waits. While the skid holds a beat the
// whole pipeline freezes and i_tri.ready is low; nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and the skid; there is no
// other state and no configuration.
module triangle_voronoi_volume_split #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tvvs_tri_if.sink          i_tri,
    tvvs_vol_if.source        o_vol
);
    import tvvs_pkg::*;

    localparam int L_M1 = mul_lat(SUM_W, SUM_W);
    localparam int L_M2 = mul_lat(SQ_W, SQ_W);
    localparam int L_Q  = Q_W + 1;
    localparam int LAT  = FRONT_LAT + L_M1 + 1 + L_M2 + L_Q + 1;

    logic                     en;
    logic [LAT-1:0]           r_vld;
    logic signed [SUM_W-1:0]  w_l2 [3];
    logic signed [SUM_W-1:0]  w_d  [3];
    logic signed [SUM_W-1:0]  w_cr [3];
    logic signed [SQ_W-1:0]   w_crsq [3];
    logic signed [SQ_W-1:0]   w_p [3];
    logic signed [T_W-1:0]    w_t [3];
    logic signed [Q_W-1:0]    w_vol [3];
    logic [S_W-1:0]           n_s;
    logic [S_W-1:0]           r_s;
    logic signed [SQ_W-1:0]   r_p [3];
    logic                     r_deg;
    logic [S_W-1:0]           r_sd [L_M2];
    logic [2:0]               r_ngd [L_M2];
    logic [L_M2+L_Q-1:0]      r_dgd;
    t_vol                     r_out;
    t_vol                     r_sk_d;
    logic                     r_sk_v;

    // pipeline advances unless the skid holds a beat
    assign en          = !r_sk_v;
    assign i_tri.ready = en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_tri.valid};
        end
    end

    // differences, edge lengths, dot products, cross product
    tvvs_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tri_d (i_tri.data),
        .o_l2    (w_l2),
        .o_d     (w_d),
        .o_cr    (w_cr)
    );

    // cross product squares and edge numerators
    for (genvar i = 0; i < 3; i++) begin : g_m1
        tvvs_mul #(.WA(SUM_W), .WB(SUM_W)) u_crsq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (w_cr[i]),
            .i_b   (w_cr[i]),
            .o_p   (w_crsq[i])
        );
        tvvs_mul #(.WA(SUM_W), .WB(SUM_W)) u_ld (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (w_l2[i]),
            .i_b   (w_d[i]),
            .o_p   (w_p[i])
        );
    end

    // squared area term and zero-area test
    always_comb begin
        n_s = S_W'($unsigned(w_crsq[0])) + S_W'($unsigned(w_crsq[1]))
            + S_W'($unsigned(w_crsq[2]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= n_s;
            r_p   <= w_p;
            r_deg <= (n_s == '0);
        end
    end

    // numerator squares
    for (genvar i = 0; i < 3; i++) begin : g_m2
        tvvs_mul #(.WA(SQ_W), .WB(SQ_W)) u_psq (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_p[i]),
            .i_b   (r_p[i]),
            .o_p   (w_t[i])
        );
    end

    // align area term and signs with the squares, and the flag with the quotient results
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0]  <= r_s;
            r_ngd[0] <= {r_p[2][SQ_W-1], r_p[1][SQ_W-1], r_p[0][SQ_W-1]};
            for (int k = 1; k < L_M2; k++) begin
                r_sd[k]  <= r_sd[k-1];
                r_ngd[k] <= r_ngd[k-1];
            end
            r_dgd <= {r_dgd[L_M2+L_Q-2:0], r_deg};
        end
    end

    // per-edge quotient search
    for (genvar i = 0; i < 3; i++) begin : g_q
        tvvs_qsearch #(.FRAC_BITS(FRAC_BITS)) u_qs (
            .i_clk (i_clk),
            .i_en  (en),
            .i_s   (r_sd[L_M2-1]),
            .i_t   ($unsigned(w_t[i])),
            .i_neg (r_ngd[L_M2-1][i]),
            .o_vol (w_vol[i])
        );
    end

    // output stage, zeros on a degenerate triangle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.vol_ab     <= r_dgd[L_M2+L_Q-1] ? '0 : w_vol[0];
            r_out.vol_ac     <= r_dgd[L_M2+L_Q-1] ? '0 : w_vol[1];
            r_out.vol_bc     <= r_dgd[L_M2+L_Q-1] ? '0 : w_vol[2];
            r_out.degenerate <= r_dgd[L_M2+L_Q-1];
        end
    end

    // skid register catches the last stage when the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (o_vol.ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_vld[LAT-1] && !o_vol.ready) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v && r_vld[LAT-1] && !o_vol.ready) begin
            r_sk_d <= r_out;
        end
    end

    assign o_vol.valid = r_sk_v || r_vld[LAT-1];
    assign o_vol.data  = r_sk_v ? r_sk_d : r_out;

    // pipeline is frozen while the skid holds a beat
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> $stable(r_vld))
        else $error("pipeline moved while skid was full");

    // skid only fills from a valid last stage that was not taken
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(r_vld[LAT-1] && !o_vol.ready))
        else $error("skid filled without a stalled beat");

    // a degenerate beat carries zero volumes
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && r_out.degenerate) |->
        (r_out.vol_ab == '0 && r_out.vol_ac == '0 && r_out.vol_bc == '0))
        else $error("degenerate beat with non-zero volume");

endmodule

>>> rtl/tvvs_mul.sv
// pipelined signed wide multiplier built from 32x32 limb products and an adder tree
module tvvs_mul #(
    parameter int WA = 67,
    parameter int WB = 67
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import tvvs_pkg::*;

    localparam int NA  = (WA + LIMB_W - 1) / LIMB_W;
    localparam int NB  = (WB + LIMB_W - 1) / LIMB_W;
    localparam int NT  = NA * NB;
    localparam int LEV = $clog2(NT);
    localparam int WF  = LIMB_W * (NA + NB);
    localparam int WP  = WA + WB;

    logic [WA-1:0]          n_ma;
    logic [WB-1:0]          n_mb;
    logic [NA*LIMB_W-1:0]   r_ma;
    logic [NB*LIMB_W-1:0]   r_mb;
    logic [LEV+1:0]         r_sg;
    logic [WF-1:0]          r_lv [LEV+1][NT];
    logic [WP-1:0]          r_p;

    // magnitudes and product sign
    always_comb begin
        n_ma = i_a[WA-1] ? $unsigned(-i_a) : $unsigned(i_a);
        n_mb = i_b[WB-1] ? $unsigned(-i_b) : $unsigned(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= (NA*LIMB_W)'(n_ma);
            r_mb <= (NB*LIMB_W)'(n_mb);
            r_sg <= {r_sg[LEV:0], i_a[WA-1] ^ i_b[WB-1]};
        end
    end

    // limb partial products, placed at their weight
    for (genvar i = 0; i < NA; i++) begin : g_pa
        for (genvar j = 0; j < NB; j++) begin : g_pb
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lv[0][i*NB+j] <= WF'((2*LIMB_W)'(r_ma[i*LIMB_W +: LIMB_W])
                                         * (2*LIMB_W)'(r_mb[j*LIMB_W +: LIMB_W]))
                                       << (LIMB_W * (i + j));
                end
            end
        end
    end

    // registered pairwise adder tree
    for (genvar l = 0; l < LEV; l++) begin : g_lv
        for (genvar k = 0; k < NT; k++) begin : g_k
            if (2*k + 1 < NT) begin : g_add
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lv[l+1][k] <= r_lv[l][2*k] + r_lv[l][2*k+1];
                    end
                end
            end else if (2*k < NT) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lv[l+1][k] <= r_lv[l][2*k];
                    end
                end
            end else begin : g_zero
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lv[l+1][k] <= '0;
                    end
                end
            end
        end
    end

    // apply the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_sg[LEV+1] ? WP'(-r_lv[LEV][0]) : WP'(r_lv[LEV][0]);
        end
    end

    assign o_p = $signed(r_p);

endmodule

>>> rtl/tvvs_front.sv
// vertex differences, products and sums: edge lengths, dot products, cross product
module tvvs_front (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  tvvs_pkg::t_tri                     i_tri_d,
    output logic signed [tvvs_pkg::SUM_W-1:0]  o_l2 [3],
    output logic signed [tvvs_pkg::SUM_W-1:0]  o_d  [3],
    output logic signed [tvvs_pkg::SUM_W-1:0]  o_cr [3]
);
    import tvvs_pkg::*;

    logic signed [COORD_W-1:0] n_pa [3];
    logic signed [COORD_W-1:0] n_pb [3];
    logic signed [COORD_W-1:0] n_pc [3];
    logic signed [DIFF_W-1:0]  r_dab [3];
    logic signed [DIFF_W-1:0]  r_dac [3];
    logic signed [DIFF_W-1:0]  r_dbc [3];
    logic signed [PROD_W-1:0]  r_sqab [3];
    logic signed [PROD_W-1:0]  r_sqac [3];
    logic signed [PROD_W-1:0]  r_sqbc [3];
    logic signed [PROD_W-1:0]  r_pacbc [3];
    logic signed [PROD_W-1:0]  r_pabbc [3];
    logic signed [PROD_W-1:0]  r_pabac [3];
    logic signed [PROD_W-1:0]  r_cr1 [3];
    logic signed [PROD_W-1:0]  r_cr2 [3];
    logic signed [SUM_W-1:0]   r_l2 [3];
    logic signed [SUM_W-1:0]   r_d [3];
    logic signed [SUM_W-1:0]   r_cr [3];

    always_comb begin
        n_pa = '{i_tri_d.a_x, i_tri_d.a_y, i_tri_d.a_z};
        n_pb = '{i_tri_d.b_x, i_tri_d.b_y, i_tri_d.b_z};
        n_pc = '{i_tri_d.c_x, i_tri_d.c_y, i_tri_d.c_z};
    end

    for (genvar i = 0; i < 3; i++) begin : g_c
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        // differences
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dab[i] <= DIFF_W'(n_pa[i]) - DIFF_W'(n_pb[i]);
                r_dac[i] <= DIFF_W'(n_pa[i]) - DIFF_W'(n_pc[i]);
                r_dbc[i] <= DIFF_W'(n_pb[i]) - DIFF_W'(n_pc[i]);
            end
        end

        // per-component products
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sqab[i]  <= PROD_W'(r_dab[i]) * PROD_W'(r_dab[i]);
                r_sqac[i]  <= PROD_W'(r_dac[i]) * PROD_W'(r_dac[i]);
                r_sqbc[i]  <= PROD_W'(r_dbc[i]) * PROD_W'(r_dbc[i]);
                r_pacbc[i] <= PROD_W'(r_dac[i]) * PROD_W'(r_dbc[i]);
                r_pabbc[i] <= PROD_W'(r_dab[i]) * PROD_W'(r_dbc[i]);
                r_pabac[i] <= PROD_W'(r_dab[i]) * PROD_W'(r_dac[i]);
                r_cr1[i]   <= PROD_W'(r_dac[J]) * PROD_W'(r_dbc[K]);
                r_cr2[i]   <= PROD_W'(r_dac[K]) * PROD_W'(r_dbc[J]);
            end
        end

        // cross product component
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cr[i] <= SUM_W'(r_cr1[i]) - SUM_W'(r_cr2[i]);
            end
        end
    end

    // squared edge lengths and opposite-vertex dot products, edge order ab, ac, bc
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l2[0] <= SUM_W'(r_sqab[0]) + SUM_W'(r_sqab[1]) + SUM_W'(r_sqab[2]);
            r_l2[1] <= SUM_W'(r_sqac[0]) + SUM_W'(r_sqac[1]) + SUM_W'(r_sqac[2]);
            r_l2[2] <= SUM_W'(r_sqbc[0]) + SUM_W'(r_sqbc[1]) + SUM_W'(r_sqbc[2]);
            r_d[0]  <= SUM_W'(r_pacbc[0]) + SUM_W'(r_pacbc[1]) + SUM_W'(r_pacbc[2]);
            r_d[1]  <= -(SUM_W'(r_pabbc[0]) + SUM_W'(r_pabbc[1]) + SUM_W'(r_pabbc[2]));
            r_d[2]  <= SUM_W'(r_pabac[0]) + SUM_W'(r_pabac[1]) + SUM_W'(r_pabac[2]);
        end
    end

    assign o_l2 = r_l2;
    assign o_d  = r_d;
    assign o_cr = r_cr;

endmodule

>>> rtl/tvvs_qsearch.sv
// one bit per stage search for the largest q with q^2 * S <= P^2 >> (2F+6), then saturation
module tvvs_qsearch #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [tvvs_pkg::S_W-1:0]         i_s,
    input  logic [tvvs_pkg::T_W-1:0]         i_t,
    input  logic                             i_neg,
    output logic signed [tvvs_pkg::Q_W-1:0]  o_vol
);
    import tvvs_pkg::*;

    localparam int SH  = 2 * FRAC_BITS + 6;
    localparam int WQS = S_W + Q_W;
    localparam int WC  = ((T_W > S_W + 2*Q_W) ? T_W : (S_W + 2*Q_W)) + 2;

    logic [Q_W-1:0] c_q   [Q_W+1];
    logic [WQS-1:0] c_qs  [Q_W+1];
    logic [T_W-1:0] c_q2s [Q_W+1];
    logic [S_W-1:0] c_s   [Q_W+1];
    logic [T_W-1:0] c_t   [Q_W+1];
    logic           c_neg [Q_W+1];
    logic [Q_W-1:0] r_q   [Q_W];
    logic [WQS-1:0] r_qs  [Q_W];
    logic [T_W-1:0] r_q2s [Q_W];
    logic [S_W-1:0] r_s   [Q_W];
    logic [T_W-1:0] r_t   [Q_W];
    logic           r_neg [Q_W];
    logic [Q_W-1:0] n_mag;
    logic [Q_W-1:0] r_vol;

    assign c_q[0]   = '0;
    assign c_qs[0]  = '0;
    assign c_q2s[0] = '0;
    assign c_s[0]   = i_s;
    assign c_t[0]   = i_t >> SH;
    assign c_neg[0] = i_neg;

    for (genvar j = 0; j < Q_W; j++) begin : g_bit
        localparam int B = Q_W - 1 - j;
        logic [WC-1:0] w_cand;
        logic          w_fit;

        // (q + 2^B)^2 * S from the running q*S and q^2*S
        assign w_cand = WC'(c_q2s[j]) + (WC'(c_qs[j]) << (B + 1)) + (WC'(c_s[j]) << (2 * B));
        assign w_fit  = (w_cand <= WC'(c_t[j]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= w_fit ? (c_q[j] | (Q_W'(1) << B)) : c_q[j];
                r_q2s[j] <= w_fit ? T_W'(w_cand) : c_q2s[j];
                r_qs[j]  <= w_fit ? (c_qs[j] + (WQS'(c_s[j]) << B)) : c_qs[j];
                r_s[j]   <= c_s[j];
                r_t[j]   <= c_t[j];
                r_neg[j] <= c_neg[j];
            end
        end

        assign c_q[j+1]   = r_q[j];
        assign c_qs[j+1]  = r_qs[j];
        assign c_q2s[j+1] = r_q2s[j];
        assign c_s[j+1]   = r_s[j];
        assign c_t[j+1]   = r_t[j];
        assign c_neg[j+1] = r_neg[j];
    end

    // saturate to 2^31 - 1 or -2^31 and apply the sign
    always_comb begin
        if (c_neg[Q_W]) begin
            n_mag = (c_q[Q_W] > (Q_W'(1) << (Q_W - 1))) ? (Q_W'(1) << (Q_W - 1)) : c_q[Q_W];
        end else begin
            n_mag = (c_q[Q_W] > ((Q_W'(1) << (Q_W - 1)) - Q_W'(1)))
                  ? ((Q_W'(1) << (Q_W - 1)) - Q_W'(1)) : c_q[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vol <= c_neg[Q_W] ? Q_W'(-n_mag) : n_mag;
        end
    end

    assign o_vol = $signed(r_vol);

endmodule
